/* rtl/core/ffp_pkg.sv */
// Shared types and constants of the first-fit two-resource placer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ffp_pkg;

  // Default table depth, register reset value and bin count limit
  localparam int MaxBinsDefault = 64;
  localparam logic [6:0] ActiveBinsReset = 7'd64;
  localparam logic [6:0] CountMax = 7'd127;

  // Operation codes carried in the mode field
  typedef enum logic [1:0] {
    ModeLoad  = 2'd0,
    ModeClear = 2'd1,
    ModePlace = 2'd2
  } mode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StClear,
    StScan,
    StResp
  } state_e;

  // Input word
  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  bin_index;
    logic [15:0] cpu_value;
    logic [23:0] ram_value;
    logic [9:0]  item_id;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic       placed;
    logic [5:0] chosen_bin;
    logic [9:0] item_id_out;
    logic [6:0] bins_in_use;
  } out_item_t;

  // Capacity entry of one bin
  typedef struct packed {
    logic [15:0] cpu;
    logic [23:0] ram;
  } cap_t;

  // Usage entry of one bin
  typedef struct packed {
    logic        occ;
    logic [15:0] cpu;
    logic [23:0] ram;
  } usage_t;

endpackage

`default_nettype wire

/* rtl/core/ffp_bin_store.sv */
// Capacity and usage memories of the bin table, one registered read port.
// Depends on ffp_pkg for the entry types.
`default_nettype none

module ffp_bin_store
  import ffp_pkg::*;
#(
  parameter int MaxBins = MaxBinsDefault,
  localparam int IdxW = (MaxBins > 1) ? $clog2(MaxBins) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            cap_we_i,
  input  wire logic [IdxW-1:0] cap_waddr_i,
  input  wire cap_t            cap_wdata_i,
  input  wire logic            use_we_i,
  input  wire logic [IdxW-1:0] use_waddr_i,
  input  wire usage_t          use_wdata_i,
  input  wire logic            rd_en_i,
  input  wire logic [IdxW-1:0] rd_addr_i,
  output cap_t                 cap_rdata_o,
  output usage_t               use_rdata_o
);

  cap_t   cap_mem [MaxBins];
  usage_t use_mem [MaxBins];
  cap_t   cap_rdata_q;
  usage_t use_rdata_q;

  // Capacity table: written by loads, never cleared
  always_ff @(posedge clk_i) begin
    if (cap_we_i) begin
      cap_mem[cap_waddr_i] <= cap_wdata_i;
    end
    if (rd_en_i) begin
      cap_rdata_q <= cap_mem[rd_addr_i];
    end
  end

  // Usage table: written by placements and clearing sweeps
  always_ff @(posedge clk_i) begin
    if (use_we_i) begin
      use_mem[use_waddr_i] <= use_wdata_i;
    end
    if (rd_en_i) begin
      use_rdata_q <= use_mem[rd_addr_i];
    end
  end

  assign cap_rdata_o = cap_rdata_q;
  assign use_rdata_o = use_rdata_q;

endmodule

`default_nettype wire

/* rtl/core/ffp_fit_eval.sv */
// Fit test of one bin against a demand, and the bin's usage after placement.
// Depends on ffp_pkg for the entry types.
`default_nettype none

module ffp_fit_eval
  import ffp_pkg::*;
(
  input  wire cap_t        cap_i,
  input  wire usage_t      usage_i,
  input  wire logic [15:0] dem_cpu_i,
  input  wire logic [23:0] dem_ram_i,
  output logic             fit_o,
  output logic             first_use_o,
  output usage_t           usage_o
);

  logic [15:0] cpu_room;
  logic [23:0] ram_room;
  logic        cpu_fit;
  logic        ram_fit;

  // Room counts as none once usage reaches capacity
  assign cpu_room = cap_i.cpu - usage_i.cpu;
  assign ram_room = cap_i.ram - usage_i.ram;
  assign cpu_fit  = (usage_i.cpu < cap_i.cpu) && (dem_cpu_i < cpu_room);
  assign ram_fit  = (usage_i.ram < cap_i.ram) && (dem_ram_i < ram_room);
  assign fit_o    = cpu_fit && ram_fit;

  // Add the demand, wrapping at the field width
  assign first_use_o = !usage_i.occ;
  assign usage_o.occ = 1'b1;
  assign usage_o.cpu = usage_i.cpu + dem_cpu_i;
  assign usage_o.ram = usage_i.ram + dem_ram_i;

endmodule

`default_nettype wire

/* rtl/core/first_fit_two_resource_placer_unit.sv */
// Top level of the first-fit two-resource placer: sequencer, output register.
// Depends on ffp_pkg, ffp_bin_store and ffp_fit_eval.
//
// Use: input words arrive on in_valid_i/in_ready_o. A load word writes one
// bin's CPU and RAM capacity, a clear word empties every bin, a place word
// is put in the first active bin with strictly more room than it needs.
// Every input word gives exactly one result word on out_valid_o/out_ready_i.
// cfg_valid_i/cfg_ready_o writes active_bins; cfg_ready_o is always high.
// Flow: the block works on one word at a time. A load or a mode 3 word
// goes straight from acceptance to the result register, a clear first
// sweeps every bin of the table, and a place reads bins in order from bin 0
// until one fits or L bins are read, L being active_bins clipped to MAX_BINS
// (straight to the result when L is zero). The scan uses the single read
// port of the bin store: one bin is read per cycle, with a registered read.
// The next word can be accepted in the cycle after a result is registered.
// Reset: the usage memory is swept to zero, one bin a cycle, over every bin;
// in_ready_o stays low meanwhile. Capacities are not cleared.
// Stall: a finished result waits in the output register; the next word is
// accepted meanwhile and, once worked out, waits until that register frees.
`default_nettype none

module first_fit_two_resource_placer_unit
  import ffp_pkg::*;
#(
  parameter int MaxBins = MaxBinsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [6:0] cfg_data_i
);

  localparam int IdxW = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  localparam int CntW = $clog2(MaxBins + 1);
  localparam logic [CntW-1:0] LastBin = CntW'(MaxBins - 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] limit_q, limit_d;
  logic [CntW-1:0] limit;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] eval_bin_q, eval_bin_d;
  logic [15:0]     dem_cpu_q, dem_cpu_d;
  logic [23:0]     dem_ram_q, dem_ram_d;
  logic [9:0]      item_q, item_d;
  logic            placed_q, placed_d;
  logic [5:0]      chosen_q, chosen_d;
  logic [6:0]      occ_cnt_q, occ_cnt_d;
  logic [6:0]      active_q;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_data_q, out_data_d;

  logic            accept;
  logic            issue;
  logic            last_sweep;
  logic            out_free;
  logic            in_range;

  logic            cap_we;
  logic [IdxW-1:0] cap_waddr;
  cap_t            cap_wdata;
  logic            use_we;
  logic [IdxW-1:0] use_waddr;
  usage_t          use_wdata;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  cap_t            cap_rdata;
  usage_t          use_rdata;
  logic            fit;
  logic            first_use;
  usage_t          next_usage;

  ffp_bin_store #(
    .MaxBins(MaxBins)
  ) u_store (
    .clk_i      (clk_i),
    .cap_we_i   (cap_we),
    .cap_waddr_i(cap_waddr),
    .cap_wdata_i(cap_wdata),
    .use_we_i   (use_we),
    .use_waddr_i(use_waddr),
    .use_wdata_i(use_wdata),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .cap_rdata_o(cap_rdata),
    .use_rdata_o(use_rdata)
  );

  ffp_fit_eval u_fit (
    .cap_i      (cap_rdata),
    .usage_i    (use_rdata),
    .dem_cpu_i  (dem_cpu_q),
    .dem_ram_i  (dem_ram_q),
    .fit_o      (fit),
    .first_use_o(first_use),
    .usage_o    (next_usage)
  );

  // Handshake and scan conditions
  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign issue       = (cnt_q < limit_q);
  assign last_sweep  = (cnt_q == LastBin);
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_range    = (32'(in_data_i.bin_index) < MaxBins);

  // Clip the scan length to the table depth
  always_comb begin
    if (32'(active_q) > MaxBins) begin
      limit = CntW'(MaxBins);
    end else begin
      limit = CntW'(active_q);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StInit: begin
        if (last_sweep) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          priority case (in_data_i.mode)
            ModeLoad:  state_d = StResp;
            ModeClear: state_d = StClear;
            ModePlace: state_d = (limit == '0) ? StResp : StScan;
            default:   state_d = StResp;
          endcase
        end
      end
      StClear: begin
        if (last_sweep) state_d = StResp;
      end
      StScan: begin
        if (rd_vld_q && fit) begin
          state_d = StResp;
        end else if (!issue) begin
          state_d = StResp;
        end
      end
      StResp: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Memory controls and datapath updates
  always_comb begin
    cnt_d       = cnt_q;
    limit_d     = limit_q;
    rd_vld_d    = rd_vld_q;
    eval_bin_d  = eval_bin_q;
    dem_cpu_d   = dem_cpu_q;
    dem_ram_d   = dem_ram_q;
    item_d      = item_q;
    placed_d    = placed_q;
    chosen_d    = chosen_q;
    occ_cnt_d   = occ_cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    cap_we      = 1'b0;
    cap_waddr   = IdxW'(in_data_i.bin_index);
    cap_wdata   = '{cpu: in_data_i.cpu_value, ram: in_data_i.ram_value};
    use_we      = 1'b0;
    use_waddr   = cnt_q[IdxW-1:0];
    use_wdata   = '0;
    rd_en       = 1'b0;
    rd_addr     = cnt_q[IdxW-1:0];

    // Drop the result once taken
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      StInit, StClear: begin
        use_we = 1'b1;
        cnt_d  = last_sweep ? '0 : cnt_q + CntW'(1);
      end
      StIdle: begin
        if (accept) begin
          dem_cpu_d = in_data_i.cpu_value;
          dem_ram_d = in_data_i.ram_value;
          item_d    = in_data_i.item_id;
          placed_d  = 1'b0;
          chosen_d  = '0;
          cnt_d     = '0;
          rd_vld_d  = 1'b0;
          limit_d   = limit;
          if (in_data_i.mode == ModeLoad) cap_we = in_range;
          if (in_data_i.mode == ModeClear) occ_cnt_d = '0;
        end
      end
      StScan: begin
        rd_en = issue;
        if (rd_vld_q && fit) begin
          use_we    = 1'b1;
          use_waddr = eval_bin_q;
          use_wdata = next_usage;
          placed_d  = 1'b1;
          chosen_d  = 6'(eval_bin_q);
          if (first_use && occ_cnt_q != CountMax) occ_cnt_d = occ_cnt_q + 7'd1;
        end else begin
          rd_vld_d   = issue;
          eval_bin_d = cnt_q[IdxW-1:0];
          if (issue) cnt_d = cnt_q + CntW'(1);
        end
      end
      StResp: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{placed:      placed_q,
                          chosen_bin:  chosen_q,
                          item_id_out: item_q,
                          bins_in_use: occ_cnt_q};
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      occ_cnt_q   <= '0;
      active_q    <= ActiveBinsReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      occ_cnt_q   <= occ_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) active_q <= cfg_data_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    limit_q    <= limit_d;
    eval_bin_q <= eval_bin_d;
    dem_cpu_q  <= dem_cpu_d;
    dem_ram_q  <= dem_ram_d;
    item_q     <= item_d;
    placed_q   <= placed_d;
    chosen_q   <= chosen_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* rtl/core/ffp_checker.sv */
// Port-level checks of the placer, and the bind that attaches them.
// Depends on ffp_pkg and on first_fit_two_resource_placer_unit.
`default_nettype none

module ffp_checker
  import ffp_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire in_item_t   in_data_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire out_item_t  out_data_o,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_o,
  input wire logic [6:0] cfg_data_i
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // One word at a time: an accepted word closes the input
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again while busy");

  // An unplaced result names bin zero
  a_unplaced_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.placed |-> out_data_o.chosen_bin == 6'd0)
    else $error("unplaced result names a bin");

  // A placement leaves at least one bin in use
  a_placed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.placed |-> out_data_o.bins_in_use != 7'd0)
    else $error("placed result with no bin in use");

endmodule

bind first_fit_two_resource_placer_unit ffp_checker u_ffp_checker (.*);

`default_nettype wire
